@@ design/vrt_pkg.sv @@
`timescale 1ns / 1ps

package vrt_pkg;

    // Width of a rank and of every per-cell count.
    localparam int RANK_W = 6;

    // Defaults handed to the top level parameters.
    localparam int MAX_ITEMS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Control part of the item that travels down the chain of cells.
    typedef struct packed {
        logic              vld;
        logic [RANK_W-1:0] cnt;
    } t_tok;

endpackage

@@ design/vrt_cell.sv @@
`timescale 1ns / 1ps

module vrt_cell
    import vrt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_tok                         i_tok,
    input  logic signed [VALUE_BITS-1:0] i_key,
    output t_tok                         o_tok,
    output logic signed [VALUE_BITS-1:0] o_key,
    input  logic                         i_shift,
    input  logic                         i_nb_vld,
    input  logic [RANK_W-1:0]            i_nb_cnt,
    output logic                         o_vld,
    output logic [RANK_W-1:0]            o_cnt
);

    logic                         r_vld;
    logic [RANK_W-1:0]            r_cnt;
    logic signed [VALUE_BITS-1:0] r_key;
    t_tok                         r_tok;
    logic signed [VALUE_BITS-1:0] r_tok_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_tok <= '0;
        end else if (i_shift) begin
            // Ranks move one cell toward the head while they are read out.
            r_vld <= i_nb_vld;
            r_cnt <= i_nb_cnt;
            r_tok <= '0;
        end else if (i_tok.vld && !r_vld) begin
            // The first empty cell takes the item and its partial count.
            r_vld     <= 1'b1;
            r_key     <= i_key;
            r_cnt     <= i_tok.cnt;
            r_tok.vld <= 1'b0;
        end else if (i_tok.vld) begin
            r_tok.vld <= 1'b1;
            r_tok_key <= i_key;
            if (r_key < i_key) begin
                r_tok.cnt <= i_tok.cnt + RANK_W'(1);
            end else begin
                r_tok.cnt <= i_tok.cnt;
            end
            if (i_key < r_key) begin
                r_cnt <= r_cnt + RANK_W'(1);
            end
        end else begin
            r_tok.vld <= 1'b0;
        end
    end

    assign o_tok = r_tok;
    assign o_key = r_tok_key;
    assign o_vld = r_vld;
    assign o_cnt = r_cnt;

endmodule

@@ design/value_rank_transform.sv @@
`timescale 1ns / 1ps
// Loading: one item per cycle while busy is low; a non-final item gives no result.
// After the final item the chain drains, and then the ranks come out in arrival order,
// one rank per cycle, one per stored item; busy stays high until the last one is out.
// The receiver cannot stall: each rank is shown for exactly one cycle.
// Reset (synchronous, active low) empties all cells and clears the fill count, the overflow flag and the strobe.

module value_rank_transform
    import vrt_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_last_value,
    output logic                         o_strobe,
    output logic [RANK_W-1:0]            o_rank,
    output logic                         o_last_rank,
    output logic                         o_dropped
);

    // Counts run from zero up to and including MAX_ITEMS.
    localparam int CW = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_wait, n_wait;
    logic [CW-1:0]     r_emit, n_emit;
    logic              r_ovf, n_ovf;
    logic              r_strobe, n_strobe;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic              r_last, n_last;
    logic              r_drop, n_drop;

    logic accept;
    logic store;
    logic shift;
    logic emit_last;

    // The chain: element i feeds cell i; the element past the tail closes it off.
    t_tok                         w_tok [MAX_ITEMS+1];
    logic signed [VALUE_BITS-1:0] w_key [MAX_ITEMS+1];
    logic                         w_vld [MAX_ITEMS+1];
    logic [RANK_W-1:0]            w_cnt [MAX_ITEMS+1];

    assign o_busy = (r_state != ST_IDLE);
    assign accept = i_start && !o_busy;
    assign store  = accept && (r_count < CW'(MAX_ITEMS));
    assign shift  = (r_state == ST_EMIT);

    // A new item enters the head cell at once, with nothing counted below it yet.
    // Each cell it passes adds itself to that count when it holds a smaller value,
    // and bumps its own count when the item is the smaller one. The first empty
    // cell keeps the item, so cells hold the set in arrival order.
    assign w_tok[0] = '{vld: store, cnt: '0};
    assign w_key[0] = i_value;
    assign w_vld[MAX_ITEMS] = 1'b0;
    assign w_cnt[MAX_ITEMS] = '0;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        vrt_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_key    (w_key[g]),
            .o_tok    (w_tok[g+1]),
            .o_key    (w_key[g+1]),
            .i_shift  (shift),
            .i_nb_vld (w_vld[g+1]),
            .i_nb_cnt (w_cnt[g+1]),
            .o_vld    (w_vld[g]),
            .o_cnt    (w_cnt[g])
        );
    end

    assign emit_last = ((r_emit + CW'(1)) == r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_wait   = r_wait;
        n_emit   = r_emit;
        n_ovf    = r_ovf;
        n_strobe = 1'b0;
        n_rank   = r_rank;
        n_last   = r_last;
        n_drop   = r_drop;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (store) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_value) begin
                        // The final item still has to walk down the chain to its
                        // cell; the wait, set from the stored count, covers that walk.
                        n_state = ST_DRAIN;
                        n_wait  = store ? r_count + CW'(1) : r_count;
                    end
                end
            end
            ST_DRAIN: begin
                if (r_wait == '0) begin
                    n_state = ST_EMIT;
                    n_emit  = '0;
                end else begin
                    n_wait = r_wait - CW'(1);
                end
            end
            ST_EMIT: begin
                // The head cell holds the next rank in arrival order; the chain
                // shifts toward the head at the same edge.
                n_strobe = 1'b1;
                n_rank   = w_cnt[0];
                n_last   = emit_last;
                n_drop   = r_ovf;
                n_emit   = r_emit + CW'(1);
                if (emit_last) begin
                    n_state = ST_IDLE;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_wait   <= '0;
            r_emit   <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_wait   <= n_wait;
            r_emit   <= n_emit;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
        r_rank <= n_rank;
        r_last <= n_last;
        r_drop <= n_drop;
    end

    assign o_strobe    = r_strobe;
    assign o_rank      = r_rank;
    assign o_last_rank = r_last;
    assign o_dropped   = r_drop;

    // An item always finds an empty cell before it runs off the tail.
    a_no_spill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tok[MAX_ITEMS].vld)
        else $error("item passed the tail cell");

    // The fill count never exceeds the number of cells.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    // Ranks are only produced by the read-out phase.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_EMIT))
        else $error("rank shown outside read-out");

    // The final rank of a set returns the block to idle with the set cleared.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_rank) |-> (r_state == ST_IDLE && r_count == '0 && !r_ovf))
        else $error("set not closed after final rank");

    // Once the chain has drained, the head cell is filled.
    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && r_wait == '0) |-> w_vld[0])
        else $error("read-out would start on an empty chain");

endmodule

@@ tb/vrt_checker.sv @@
`timescale 1ns / 1ps

// Watches the item and rank channels of value_rank_transform, keeps its own
// copy of the set being loaded and compares every rank that comes out.
module vrt_checker
    import vrt_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_last_value,
    input  logic                         i_strobe,
    input  logic [RANK_W-1:0]            i_rank,
    input  logic                         i_last_rank,
    input  logic                         i_dropped,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic              last_rank;
        logic              dropped;
    } t_rank_rec;

    t_rank_rec                    expected_ranks[$];
    logic signed [VALUE_BITS-1:0] set_values[MAX_ITEMS];
    logic [RANK_W-1:0]            smaller_in_set[MAX_ITEMS];
    int                           set_len;
    logic                         set_overflow;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        set_len      = 0;
        set_overflow = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: rank mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    // Adds one value to the set; on the final value queues the ranks of the set.
    task automatic rank_value(input logic signed [VALUE_BITS-1:0] value, input logic last);
        int        below;
        t_rank_rec rec;
        below = 0;
        if (set_len >= MAX_ITEMS) begin
            set_overflow = 1'b1;
        end else begin
            for (int i = 0; i < set_len; i++) begin
                if (set_values[i] < value) begin
                    below++;
                end else if (value < set_values[i]) begin
                    smaller_in_set[i] = smaller_in_set[i] + 1'b1;
                end
            end
            set_values[set_len]     = value;
            smaller_in_set[set_len] = below[RANK_W-1:0];
            set_len++;
        end
        if (last) begin
            for (int i = 0; i < set_len; i++) begin
                rec.rank      = smaller_in_set[i];
                rec.last_rank = (i + 1 == set_len);
                rec.dropped   = set_overflow;
                expected_ranks.push_back(rec);
            end
            set_len      = 0;
            set_overflow = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_rank_rec want;
        if (!i_rst_n) begin
            expected_ranks.delete();
            set_len      = 0;
            set_overflow = 1'b0;
        end else begin
            if (i_strobe) begin
                if (expected_ranks.size() == 0) begin
                    report_mismatch("unexpected rank, nothing pending", i_rank, -1);
                end else begin
                    want = expected_ranks.pop_front();
                    if (i_rank !== want.rank) begin
                        report_mismatch("rank", i_rank, want.rank);
                    end
                    if (i_last_rank !== want.last_rank) begin
                        report_mismatch("last_rank", i_last_rank, want.last_rank);
                    end
                    if (i_dropped !== want.dropped) begin
                        report_mismatch("dropped", i_dropped, want.dropped);
                    end
                end
            end
            if (i_start && !i_busy) begin
                rank_value(i_value, i_last_value);
            end
        end
        o_pending = expected_ranks.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench top for value_rank_transform. It only makes stimulus and gives the
// verdict; the checker beside the block predicts and compares every rank.
module tb_top;
    import vrt_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic signed [31:0] i_value;
    logic               i_last_value;
    logic               o_busy;
    logic               o_strobe;
    logic [RANK_W-1:0]  o_rank;
    logic               o_last_rank;
    logic               o_dropped;
    int                 fail_count;
    int                 ranks_pending;

    // Number of items sent so far, and whether the sender may pause at random.
    int                 items_sent;
    bit                 allow_idle;

    value_rank_transform i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_value     (i_value),
        .i_last_value(i_last_value),
        .o_strobe    (o_strobe),
        .o_rank      (o_rank),
        .o_last_rank (o_last_rank),
        .o_dropped   (o_dropped)
    );

    vrt_checker u_rank_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_busy      (o_busy),
        .i_value     (i_value),
        .i_last_value(i_last_value),
        .i_strobe    (o_strobe),
        .i_rank      (o_rank),
        .i_last_rank (o_last_rank),
        .i_dropped   (o_dropped),
        .o_fail_count(fail_count),
        .o_pending   (ranks_pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Picks a value: small values give many ties, the extremes hit the ends of
    // the signed range, and full random words toggle every bit.
    function automatic logic signed [31:0] pick_value();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode <= 3) begin
            return $signed($urandom_range(0, 6)) - 3;
        end else if (mode == 4) begin
            case ($urandom_range(0, 6))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh8000_0001;
                3: return 32'sh7fff_fffe;
                4: return -1;
                5: return 1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    // Presents one item and holds it until the block takes it. The pre-edge
    // value of busy is read right after the edge, which is exactly what the
    // block saw when it decided whether to accept. A random pause may come
    // first, with start low and junk on the data lines, so that pauses land
    // both during loading and while ranks are streaming out.
    task automatic send_item(input logic signed [31:0] value, input logic last);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            i_start      <= 1'b0;
            i_value      <= $urandom;
            i_last_value <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_value      <= value;
        i_last_value <= last;
        do begin
            @(posedge i_clk);
        end while (o_busy);
        items_sent++;
    endtask

    initial begin
        logic signed [31:0] directed_vals[14];
        bit                 directed_last[14];
        int                 set_size;
        int                 set_index;

        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_value      = '0;
        i_last_value = 1'b0;
        items_sent   = 0;
        allow_idle   = 1'b1;

        // Directed sets: a lone final value, the signed extremes with ties,
        // two equal values, and a strictly descending run.
        directed_vals = '{32'sh8000_0000,
                          32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 32'sh7fff_ffff,
                          32'sh8000_0000,
                          5, 5,
                          3, 2, 1, 0, -7};
        directed_last = '{1,
                          0, 0, 0, 0, 0, 1,
                          0, 1,
                          0, 0, 0, 0, 1};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_vals[k]) begin
            send_item(directed_vals[k], directed_last[k]);
        end

        // Random sets. The first overruns the capacity, so its final value is
        // itself dropped; the second fills the cells exactly; the rest are mostly
        // small sets with the odd medium, full or overrunning one.
        set_index = 0;
        while (items_sent < 430) begin
            if (set_index == 0) begin
                set_size = 65 + $urandom_range(0, 5);
            end else if (set_index == 1) begin
                set_size = 64;
            end else begin
                case ($urandom_range(0, 19))
                    0: set_size = 65 + $urandom_range(0, 5);
                    1: set_size = 64;
                    2, 3, 4: set_size = $urandom_range(11, 40);
                    default: set_size = $urandom_range(1, 10);
                endcase
            end
            for (int j = 0; j < set_size; j++) begin
                // The tail of the run goes without any pauses.
                allow_idle = (items_sent < 365);
                send_item(pick_value(), j == set_size - 1);
            end
            set_index++;
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (ranks_pending != 0) begin
            @(posedge i_clk);
        end
        // Room for any stray rank the block might still put out.
        repeat (100) @(posedge i_clk);

        if (fail_count == 0 && ranks_pending == 0) begin
            $display("value_rank_transform test passed");
        end else begin
            $display("value_rank_transform test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("value_rank_transform test failed");
        $finish;
    end

endmodule

@@ files.f @@
design/vrt_pkg.sv
design/vrt_cell.sv
design/value_rank_transform.sv
tb/vrt_checker.sv
tb/tb_top.sv
